// ===== design/two_byte_header_frame_sync_assert.svh =====
// Assertion macros for the header frame sync block
`ifndef TWO_BYTE_HEADER_FRAME_SYNC_ASSERT_SVH
`define TWO_BYTE_HEADER_FRAME_SYNC_ASSERT_SVH

// same-cycle implication
`define TBHFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbhfs same-cycle check failed");

// next-cycle implication
`define TBHFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbhfs next-cycle check failed");

`endif

// ===== design/tbhfs_pkg.sv =====
`default_nettype none

package tbhfs_pkg;

  localparam logic [7:0] LENGTH_POSITION = 8'd5;
  localparam logic [7:0] MAX_FRAME = 8'd255;
  localparam logic [7:0] MIN_VAR_SIZE = LENGTH_POSITION + 8'd1;
  localparam logic [7:0] MIN_SIZE = 8'd2;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_FROM_FIELD = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] base_length;
    logic [7:0] block_length;
    logic       length_from_field;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        frame_overrun;
    logic [31:0] frames_received;
    logic [31:0] frames_lost;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ===== design/tbhfs_regs.sv =====
`default_nettype none

module tbhfs_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tbhfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                         cfg_data,
  output tbhfs_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first      <= 8'd0;
      cfg.header_second     <= 8'd0;
      cfg.base_length       <= 8'd6;
      cfg.block_length      <= 8'd15;
      cfg.length_from_field <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        tbhfs_pkg::REG_HEADER_FIRST:      cfg.header_first <= cfg_data;
        tbhfs_pkg::REG_HEADER_SECOND:     cfg.header_second <= cfg_data;
        tbhfs_pkg::REG_BASE_LENGTH:       cfg.base_length <= cfg_data;
        tbhfs_pkg::REG_BLOCK_LENGTH:      cfg.block_length <= cfg_data;
        tbhfs_pkg::REG_LENGTH_FROM_FIELD: cfg.length_from_field <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tbhfs_core.sv =====
`default_nettype none

module tbhfs_core (
  input  logic              clk,
  input  logic              rst,
  input  tbhfs_pkg::cfg_t   cfg,
  input  logic              fire,
  input  logic              mode,
  input  logic [7:0]        rx_byte,
  output tbhfs_pkg::push_t  push
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_SECOND = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  position, position_next;
  logic [7:0]  frame_size, frame_size_next;
  logic        frame_pending, frame_pending_next;
  logic [31:0] received_total, received_total_next;
  logic [31:0] lost_total, lost_total_next;

  logic [7:0]  fixed_size;
  logic [15:0] product;
  logic [16:0] var_sum;
  logic [7:0]  var_size;
  logic [7:0]  pos_inc;
  logic [31:0] fin_received;
  logic [31:0] fin_lost;
  logic [7:0]  hunt_size;
  logic        last;

  always_comb begin
    if (cfg.base_length < tbhfs_pkg::MIN_SIZE) begin
      fixed_size = tbhfs_pkg::MIN_SIZE;
    end else if (cfg.base_length > tbhfs_pkg::MAX_FRAME) begin
      fixed_size = tbhfs_pkg::MAX_FRAME;
    end else begin
      fixed_size = cfg.base_length;
    end
    product = {8'd0, rx_byte} * {8'd0, cfg.block_length};
    var_sum = {9'd0, cfg.base_length} + {1'b0, product};
    if (var_sum > {9'd0, tbhfs_pkg::MAX_FRAME}) begin
      var_size = tbhfs_pkg::MAX_FRAME;
    end else begin
      var_size = var_sum[7:0];
    end
    if (var_size < tbhfs_pkg::MIN_VAR_SIZE) begin
      var_size = tbhfs_pkg::MIN_VAR_SIZE;
    end
    hunt_size = cfg.length_from_field ? tbhfs_pkg::MAX_FRAME : fixed_size;
    pos_inc = position + 8'd1;
    fin_received = received_total + 32'd1;
    fin_lost = lost_total + {31'd0, frame_pending};
  end

  always_comb begin
    phase_next = phase;
    position_next = position;
    frame_size_next = frame_size;
    frame_pending_next = frame_pending;
    received_total_next = received_total;
    lost_total_next = lost_total;
    push = '0;
    last = 1'b0;
    if (fire) begin
      if (mode) begin
        frame_pending_next = 1'b0;
      end else begin
        case (phase)
          PH_SECOND: begin
            if (rx_byte == cfg.header_second) begin
              frame_size_next = hunt_size;
              last = (hunt_size <= tbhfs_pkg::MIN_SIZE);
              push.count = 2'd2;
              push.r0.data_byte = cfg.header_first;
              push.r0.first_of_frame = 1'b1;
              push.r0.frames_received = received_total;
              push.r0.frames_lost = lost_total;
              push.r1.data_byte = rx_byte;
              push.r1.last_of_frame = last;
              push.r1.run_last = 1'b1;
              if (last) begin
                push.r1.frame_overrun = frame_pending;
                push.r1.frames_received = fin_received;
                push.r1.frames_lost = fin_lost;
                received_total_next = fin_received;
                lost_total_next = fin_lost;
                frame_pending_next = 1'b1;
                phase_next = PH_HUNT;
                position_next = 8'd0;
              end else begin
                push.r1.frames_received = received_total;
                push.r1.frames_lost = lost_total;
                phase_next = PH_BODY;
                position_next = 8'd1;
              end
            end else begin
              phase_next = (rx_byte == cfg.header_first) ? PH_SECOND : PH_HUNT;
            end
          end
          PH_BODY: begin
            if (pos_inc == tbhfs_pkg::LENGTH_POSITION && cfg.length_from_field) begin
              frame_size_next = var_size;
            end
            last = ({1'b0, pos_inc} + 9'd1) >= {1'b0, frame_size_next};
            push.count = 2'd1;
            push.r0.data_byte = rx_byte;
            push.r0.last_of_frame = last;
            push.r0.run_last = 1'b1;
            position_next = pos_inc;
            if (last) begin
              push.r0.frame_overrun = frame_pending;
              push.r0.frames_received = fin_received;
              push.r0.frames_lost = fin_lost;
              received_total_next = fin_received;
              lost_total_next = fin_lost;
              frame_pending_next = 1'b1;
              phase_next = PH_HUNT;
              position_next = 8'd0;
            end else begin
              push.r0.frames_received = received_total;
              push.r0.frames_lost = lost_total;
            end
          end
          default: begin
            phase_next = (rx_byte == cfg.header_first) ? PH_SECOND : PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      position <= 8'd0;
      frame_size <= 8'd0;
      frame_pending <= 1'b0;
      received_total <= 32'd0;
      lost_total <= 32'd0;
    end else begin
      phase <= phase_next;
      position <= position_next;
      frame_size <= frame_size_next;
      frame_pending <= frame_pending_next;
      received_total <= received_total_next;
      lost_total <= lost_total_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tbhfs_fifo.sv =====
`default_nettype none

module tbhfs_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  tbhfs_pkg::push_t                  push,
  input  logic                              pop,
  output tbhfs_pkg::result_t                head,
  output logic [tbhfs_pkg::QUEUE_LVL_W-1:0] level
);

  tbhfs_pkg::result_t mem [tbhfs_pkg::QUEUE_DEPTH];

  logic [tbhfs_pkg::QUEUE_IDX_W-1:0] wr_ptr;
  logic [tbhfs_pkg::QUEUE_IDX_W-1:0] rd_ptr;
  logic [tbhfs_pkg::QUEUE_IDX_W-1:0] wr_ptr_plus;

  assign wr_ptr_plus = wr_ptr + tbhfs_pkg::QUEUE_IDX_W'(1);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr + tbhfs_pkg::QUEUE_IDX_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + tbhfs_pkg::QUEUE_IDX_W'(1);
      end
      level <= level + tbhfs_pkg::QUEUE_LVL_W'(push.count)
             - tbhfs_pkg::QUEUE_LVL_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/two_byte_header_frame_sync.sv =====
// Two-byte header frame sync.
// Request channel: item_valid / item_stall with mode and rx_byte. A mode of 0 carries a
// received byte, a mode of 1 acknowledges the last frame and gives no result.
// Result channel: result_valid / result_stall with one frame byte and its flags and
// frame counters per result; a confirmed header gives two results, a body byte one.
// Configuration: cfg_write, cfg_index, cfg_data write one register per cycle.
// Throughput: one request per cycle while item_stall is low. A request is held in an
// input register and settled in one pass into a four-entry result queue; it moves on
// only while at least two entries are free, so a receiver that takes one result per
// cycle never slows the byte stream, and header pairs drain from the queue in the idle
// cycles that follow.
// While the receiver stalls, the queue fills and item_stall rises once a waiting
// request no longer fits; nothing is dropped.
// Reset (rst, synchronous): hunting for the header, counters and pending mark at zero,
// queue empty, registers at 0, 0, 6, 15, 1.
`default_nettype none
`include "two_byte_header_frame_sync_assert.svh"

module two_byte_header_frame_sync (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tbhfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              mode,
  input  logic [7:0]                        rx_byte,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [7:0]                        data_byte,
  output logic                              first_of_frame,
  output logic                              last_of_frame,
  output logic                              frame_overrun,
  output logic [31:0]                       frames_received,
  output logic [31:0]                       frames_lost,
  output logic                              run_last
);

  tbhfs_pkg::cfg_t    cfg;
  tbhfs_pkg::push_t   push;
  tbhfs_pkg::result_t head;

  logic [tbhfs_pkg::QUEUE_LVL_W-1:0] level;

  logic       item_q_valid;
  logic       item_q_mode;
  logic [7:0] item_q_byte;
  logic       room;
  logic       fire;
  logic       pop;

  assign room = level <= tbhfs_pkg::QUEUE_LVL_W'(tbhfs_pkg::QUEUE_DEPTH - 2);
  assign fire = item_q_valid && room;
  assign item_stall = item_q_valid && !room;
  assign result_valid = level != '0;
  assign pop = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (fire) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q_mode <= mode;
      item_q_byte <= rx_byte;
    end
  end

  tbhfs_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbhfs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .mode    (item_q_mode),
    .rx_byte (item_q_byte),
    .push    (push)
  );

  tbhfs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  assign data_byte       = head.data_byte;
  assign first_of_frame  = head.first_of_frame;
  assign last_of_frame   = head.last_of_frame;
  assign frame_overrun   = head.frame_overrun;
  assign frames_received = head.frames_received;
  assign frames_lost     = head.frames_lost;
  assign run_last        = head.run_last;

  `TBHFS_ASSERT_IMPL(a_level_max, 1'b1, level <= tbhfs_pkg::QUEUE_LVL_W'(tbhfs_pkg::QUEUE_DEPTH))
  `TBHFS_ASSERT_NEXT(a_hold_request, item_q_valid && item_stall, item_q_valid)
  `TBHFS_ASSERT_IMPL(a_first_not_last, result_valid && first_of_frame, !last_of_frame && !run_last)
  `TBHFS_ASSERT_IMPL(a_overrun_on_last, result_valid && frame_overrun, last_of_frame)

endmodule

`default_nettype wire
